// ===== sv/imrot_pkg.sv =====
`timescale 1ns / 1ps

package imrot_pkg;

    // operation field codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // configuration register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam logic [1:0]  REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0]  REG_FRAME_HEIGHT = 2'd1;
    localparam int          CFG_DATA_W       = 9;

    localparam int          PIX_W            = 8;

    // controller to datapath commands for the current cycle
    typedef struct packed {
        logic load;   // store s_pixel_in at the load position, advance it
        logic fetch;  // read the rotated pixel into the output register
    } ctrl_cmd_t;

endpackage

// ===== sv/imrot_ctrl.sv =====
`timescale 1ns / 1ps

module imrot_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_operation,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output imrot_pkg::ctrl_cmd_t cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg;
    state_t state_next;

    // loads never touch the output register, so they pass a stalled result
    assign s_ready   = (s_operation == imrot_pkg::OP_LOAD) || (state_reg == ST_EMPTY) || m_ready;
    assign cmd.load  = s_valid && s_ready && (s_operation == imrot_pkg::OP_LOAD);
    assign cmd.fetch = s_valid && s_ready && (s_operation == imrot_pkg::OP_FETCH);
    assign m_valid   = (state_reg == ST_FULL);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY: begin
                if (cmd.fetch) state_next = ST_FULL;
            end
            ST_FULL: begin
                if (cmd.fetch) state_next = ST_FULL;
                else if (m_ready) state_next = ST_EMPTY;
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/imrot_dpath.sv =====
`timescale 1ns / 1ps

module imrot_dpath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  imrot_pkg::ctrl_cmd_t                cmd,
    input  logic                                cfg_wen,
    input  logic [imrot_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imrot_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [imrot_pkg::PIX_W-1:0]         pixel_in,
    output logic [imrot_pkg::PIX_W-1:0]         pixel_out,
    output logic                                row_end,
    output logic                                frame_end
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WD_W    = $clog2(MAX_WIDTH + 1);
    localparam int HT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int RST_WD  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int RST_HT  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    logic [WD_W-1:0]  width_reg,    width_next;
    logic [HT_W-1:0]  height_reg,   height_next;
    logic [COL_W-1:0] load_col_reg, load_col_next;
    logic [ROW_W-1:0] load_row_reg, load_row_next;
    logic [COL_W-1:0] emit_row_reg, emit_row_next;
    logic [ROW_W-1:0] emit_col_reg, emit_col_next;

    logic [WD_W-1:0]  width_clamped;
    logic [HT_W-1:0]  height_clamped;
    logic             load_col_last, load_row_last;
    logic             emit_col_last, emit_row_last;
    logic [WD_W-1:0]  src_col_full;
    logic [ADDR_W-1:0] load_addr, fetch_addr;

    logic [imrot_pkg::PIX_W-1:0] mem [0:DEPTH-1];
    logic [imrot_pkg::PIX_W-1:0] pixel_out_reg;
    logic                        row_end_reg, frame_end_reg;

    // zero reads as one, anything above the maximum saturates
    always_comb begin
        if (cfg_wdata == '0) width_clamped = WD_W'(1);
        else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) width_clamped = WD_W'(MAX_WIDTH);
        else width_clamped = WD_W'(cfg_wdata);

        if (cfg_wdata == '0) height_clamped = HT_W'(1);
        else if (32'(cfg_wdata) > 32'(MAX_HEIGHT)) height_clamped = HT_W'(MAX_HEIGHT);
        else height_clamped = HT_W'(cfg_wdata);
    end

    assign load_col_last = (WD_W'(load_col_reg) + WD_W'(1)) == width_reg;
    assign load_row_last = (HT_W'(load_row_reg) + HT_W'(1)) == height_reg;
    assign emit_col_last = (HT_W'(emit_col_reg) + HT_W'(1)) == height_reg;
    assign emit_row_last = (WD_W'(emit_row_reg) + WD_W'(1)) == width_reg;

    // output (r, c) comes from input (c, width-1-r)
    assign src_col_full = width_reg - WD_W'(1) - WD_W'(emit_row_reg);
    assign load_addr    = {load_row_reg, load_col_reg};
    assign fetch_addr   = {emit_col_reg, src_col_full[COL_W-1:0]};

    always_comb begin
        width_next    = width_reg;
        height_next   = height_reg;
        load_col_next = load_col_reg;
        load_row_next = load_row_reg;
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;

        if (cfg_wen && (cfg_index == imrot_pkg::REG_FRAME_WIDTH ||
                        cfg_index == imrot_pkg::REG_FRAME_HEIGHT)) begin
            if (cfg_index == imrot_pkg::REG_FRAME_WIDTH) width_next = width_clamped;
            else height_next = height_clamped;
            load_col_next = '0;
            load_row_next = '0;
            emit_row_next = '0;
            emit_col_next = '0;
        end else begin
            if (cmd.load) begin
                if (load_col_last) begin
                    load_col_next = '0;
                    load_row_next = load_row_last ? '0 : load_row_reg + ROW_W'(1);
                end else begin
                    load_col_next = load_col_reg + COL_W'(1);
                end
            end
            if (cmd.fetch) begin
                if (emit_col_last) begin
                    emit_col_next = '0;
                    emit_row_next = emit_row_last ? '0 : emit_row_reg + COL_W'(1);
                end else begin
                    emit_col_next = emit_col_reg + ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WD_W'(RST_WD);
            height_reg   <= HT_W'(RST_HT);
            load_col_reg <= '0;
            load_row_reg <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            load_col_reg <= load_col_next;
            load_row_reg <= load_row_next;
            emit_row_reg <= emit_row_next;
            emit_col_reg <= emit_col_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[load_addr] <= pixel_in;
        end
    end

    // read data register doubles as the output register; holds while stalled
    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            pixel_out_reg <= mem[fetch_addr];
            row_end_reg   <= emit_col_last;
            frame_end_reg <= emit_col_last && emit_row_last;
        end
    end

    assign pixel_out = pixel_out_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== sv/image_rotate_ccw90_unit.sv =====
`timescale 1ns / 1ps
// Rotates a grayscale frame 90 degrees anticlockwise.
// Input channel (s_*): each beat is a load (s_operation = 0), which stores s_pixel_in
// at the next input raster position, or a fetch (s_operation = 1), which returns
// the next pixel of the rotated frame in output raster order on the m_* channel.
// The rotated frame is frame_height wide and frame_width tall; m_row_end flags the
// last pixel of each output row, m_frame_end the last pixel of the frame.
// Both position counters wrap at the end of a frame. Write frame_width (index 0)
// and frame_height (index 1) through cfg_wen/cfg_index/cfg_wdata while idle; any
// such write restarts loading and fetching at pixel 0. A value of 0 is taken as 1,
// values above the maximum saturate.
// One beat per cycle in both directions while the receiver keeps up. A fetch shows
// its result in the cycle after acceptance; the frame store's single registered read port is the output register.
// While the receiver stalls, loads are still taken, fetches wait.
// Reset: width and height return to 256 (capped at the maximum), positions to 0,
// no result pending. Frame store contents survive reset and need no clearing.
module image_rotate_ccw90_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [imrot_pkg::PIX_W-1:0]         s_pixel_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [imrot_pkg::PIX_W-1:0]         m_pixel_out,
    output logic                                m_row_end,
    output logic                                m_frame_end,
    input  logic                                cfg_wen,
    input  logic [imrot_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imrot_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    imrot_pkg::ctrl_cmd_t cmd;

    imrot_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    imrot_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pixel_in  (s_pixel_in),
        .pixel_out (m_pixel_out),
        .row_end   (m_row_end),
        .frame_end (m_frame_end)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int PIX_W      = imrot_pkg::PIX_W;
    localparam int CFG_IDX_W  = imrot_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = imrot_pkg::CFG_DATA_W;

    localparam int MAX_DIM     = 256;
    localparam int TOTAL_BEATS = 1970;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;

    // indexes the block does not decode; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
    } rotated_px_t;

    class rotate_scoreboard;
        logic [PIX_W-1:0] frame_mem [MAX_DIM*MAX_DIM];
        bit               loaded    [MAX_DIM*MAX_DIM];
        int unsigned      frame_w, frame_h;
        int unsigned      load_row, load_col, emit_row, emit_col;
        rotated_px_t      rotated_q [$];
        int               errors;

        function new();
            frame_w = MAX_DIM;
            frame_h = MAX_DIM;
            errors  = 0;
            rewind();
        endfunction

        function void rewind();
            load_row = 0;
            load_col = 0;
            emit_row = 0;
            emit_col = 0;
        endfunction

        function int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return 32'(v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx,
                                logic [CFG_DATA_W-1:0] val);
            case (idx)
                imrot_pkg::REG_FRAME_WIDTH: begin
                    frame_w = clamp_dim(val);
                    rewind();
                end
                imrot_pkg::REG_FRAME_HEIGHT: begin
                    frame_h = clamp_dim(val);
                    rewind();
                end
                default: ;
            endcase
        endfunction

        // source of the next fetch: input row = output column, mirrored column
        function int unsigned fetch_addr();
            return emit_col * MAX_DIM + (frame_w - 1 - emit_row);
        endfunction

        function bit fetch_ready();
            return loaded[fetch_addr()];
        endfunction

        function int pending();
            return rotated_q.size();
        endfunction

        function void note_input_beat(logic op, logic [PIX_W-1:0] px);
            int unsigned addr;
            rotated_px_t res;
            if (op == imrot_pkg::OP_LOAD) begin
                addr = load_row * MAX_DIM + load_col;
                frame_mem[addr] = px;
                loaded[addr]    = 1'b1;
                if (load_col + 1 >= frame_w) begin
                    load_col = 0;
                    load_row = (load_row + 1 >= frame_h) ? 0 : load_row + 1;
                end else begin
                    load_col++;
                end
            end else begin
                res.pixel     = frame_mem[fetch_addr()];
                res.row_end   = (emit_col + 1 >= frame_h);
                res.frame_end = res.row_end && (emit_row + 1 >= frame_w);
                rotated_q.push_back(res);
                if (res.row_end) begin
                    emit_col = 0;
                    emit_row = res.frame_end ? 0 : emit_row + 1;
                end else begin
                    emit_col++;
                end
            end
        endfunction

        function void check_output_beat(logic [PIX_W-1:0] px, logic re, logic fe);
            rotated_px_t exp_px;
            if (rotated_q.size() == 0) begin
                $display("%0t: unexpected result beat, pixel_out %02h row_end %b frame_end %b",
                         $time, px, re, fe);
                errors++;
                return;
            end
            exp_px = rotated_q.pop_front();
            if (px !== exp_px.pixel) begin
                $display("%0t: pixel_out expected %02h actual %02h", $time, exp_px.pixel, px);
                errors++;
            end
            if (re !== exp_px.row_end) begin
                $display("%0t: row_end expected %b actual %b", $time, exp_px.row_end, re);
                errors++;
            end
            if (fe !== exp_px.frame_end) begin
                $display("%0t: frame_end expected %b actual %b", $time, exp_px.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_operation = imrot_pkg::OP_LOAD;
    logic [PIX_W-1:0]      s_pixel_in  = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [PIX_W-1:0]      m_pixel_out;
    logic                  m_row_end;
    logic                  m_frame_end;
    logic                  cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = imrot_pkg::REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

    rotate_scoreboard sb = new();

    int src_idle_pct  = 10;
    int sink_idle_pct = 66;
    int beats_sent    = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    bit hold_start    = 1'b0;

    image_rotate_ccw90_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: check accepted beats, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_output_beat(m_pixel_out, m_row_end, m_frame_end);
        if (hold_start) begin
            hold_start = 1'b0;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // leaves s_valid high after the accepting edge; caller sends again or drains
    task automatic send_beat(input logic op, input logic [PIX_W-1:0] px);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_pixel_in  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input_beat(op, px);
        beats_sent++;
    endtask

    // a fetch is only sent when its source pixel has been loaded
    task automatic send_gated(input bit want_fetch);
        if (want_fetch && sb.fetch_ready())
            send_beat(imrot_pkg::OP_FETCH, PIX_W'($urandom_range(0, 255)));
        else
            send_beat(imrot_pkg::OP_LOAD, PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [PIX_W-1:0] seed_px [6];
        int w_val, h_val, mode, n, fetch_pct, phase;
        bit hold_done, pressure;

        seed_px = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80};
        hold_done = 1'b0;
        phase = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 3x2 frame: full rotation, fetch wrap, load wrap over pixel 0
        write_cfg(imrot_pkg::REG_FRAME_WIDTH, 9'd3);
        write_cfg(imrot_pkg::REG_FRAME_HEIGHT, 9'd2);
        foreach (seed_px[i]) send_beat(imrot_pkg::OP_LOAD, seed_px[i]);
        repeat (7) send_beat(imrot_pkg::OP_FETCH, 8'h00);
        send_beat(imrot_pkg::OP_LOAD, 8'h7F);
        drain_results();
        // undecoded index must not disturb the positions
        write_cfg(REG_UNUSED_3, 9'h1FF);
        repeat (2) send_beat(imrot_pkg::OP_FETCH, 8'hFF);
        drain_results();
        // zero dims are taken as 1: every fetch ends the frame
        write_cfg(imrot_pkg::REG_FRAME_WIDTH, 9'd0);
        write_cfg(imrot_pkg::REG_FRAME_HEIGHT, 9'd0);
        send_beat(imrot_pkg::OP_LOAD, 8'h3C);
        repeat (2) send_beat(imrot_pkg::OP_FETCH, 8'h00);

        while (beats_sent < TOTAL_BEATS) begin
            drain_results();
            if (beats_sent < 650) begin
                src_idle_pct  = 10;
                sink_idle_pct = 66;
            end else if (beats_sent < 1300) begin
                src_idle_pct  = 66;
                sink_idle_pct = 10;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            pressure = 1'b0;
            if (phase == 1) begin
                w_val = 511;
                h_val = 1;
                mode  = 0;
            end else if (phase == 3) begin
                w_val = 0;
                h_val = 256;
                mode  = 0;
            end else if (!hold_done && beats_sent >= 1300) begin
                w_val     = 8;
                h_val     = 8;
                mode      = 0;
                hold_done = 1'b1;
                pressure  = 1'b1;
            end else begin
                w_val = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                h_val = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                mode  = $urandom_range(0, 9);
            end
            if ($urandom_range(0, 1)) begin
                write_cfg(imrot_pkg::REG_FRAME_WIDTH, CFG_DATA_W'(w_val));
                write_cfg(imrot_pkg::REG_FRAME_HEIGHT, CFG_DATA_W'(h_val));
            end else begin
                write_cfg(imrot_pkg::REG_FRAME_HEIGHT, CFG_DATA_W'(h_val));
                write_cfg(imrot_pkg::REG_FRAME_WIDTH, CFG_DATA_W'(w_val));
            end
            if ($urandom_range(0, 3) == 0)
                write_cfg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                          CFG_DATA_W'($urandom_range(0, 511)));
            n = sb.frame_w * sb.frame_h;
            if (pressure) hold_start = 1'b1;
            if (mode <= 5) begin
                repeat (n) send_gated(1'b0);
                repeat (n) send_gated(1'b1);
            end else begin
                // mode 9 sends a partial frame first; then a random mix of loads and fetches
                if (mode == 9) repeat ($urandom_range(0, n - 1)) send_gated(1'b0);
                fetch_pct = $urandom_range(20, 80);
                repeat (2 * n + $urandom_range(0, n))
                    send_gated($urandom_range(0, 99) < fetch_pct);
            end
            phase++;
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
